>>> rtl/iol_pkg.sv
// iol_pkg: shared constants, types and elaboration helpers for the indexed ordered list.
// No dependencies. Used by the interfaces, the cell, the merge node and the top level.
`timescale 1ns / 1ps

package iol_pkg;

  // List capacity and derived widths
  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the transaction payloads
  localparam int ACTION_W = 2;
  localparam int POS_W    = 10;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 8;
  localparam int OCC_W    = 9;

  // Width used to compare a signed position against the element count
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

  // Selection tree: fan-in per node and number of registered levels above the cells
  localparam int RADIX = 8;

  function automatic int tree_levels(int n);
    int lv;
    int span;
    lv   = 0;
    span = 1;
    while (span < n) begin
      span = span * RADIX;
      lv   = lv + 1;
    end
    return lv;
  endfunction

  localparam int LVL    = tree_levels(CAPACITY);
  localparam int PAD    = RADIX ** LVL;
  localparam int WAIT_W = $clog2(LVL + 1);

  // Start of tree level lv in the flat node array (level 0 = leaves)
  function automatic int level_off(int lv);
    int off;
    off = 0;
    for (int k = 0; k < lv; k++) begin
      off = off + RADIX ** (LVL - k);
    end
    return off;
  endfunction

  localparam int TOTAL = level_off(LVL + 1);

  // One tree entry: a hit flag, the cell position and the cell word
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
  } node_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic              ins_en;
    logic              pop_en;
    logic              sel_find;
    logic              sel_pop;
    logic [IDX_W-1:0]  at;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] key;
  } cell_ctrl_t;

endpackage

>>> rtl/iol_if.sv
// iol_if: valid/ready channel interfaces for request and response transactions.
// Depends on iol_pkg for field widths.
`timescale 1ns / 1ps

interface iol_req_if;
  logic                           valid;
  logic                           ready;
  logic [iol_pkg::ACTION_W-1:0]   action;
  logic signed [iol_pkg::POS_W-1:0] position;
  logic [iol_pkg::WORD_W-1:0]     data_word;

  modport source (output valid, output action, output position, output data_word,
                  input ready);
  modport sink   (input valid, input action, input position, input data_word,
                  output ready);
endinterface

interface iol_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [iol_pkg::STATUS_W-1:0] status;
  logic [iol_pkg::WORD_W-1:0]   popped_word;
  logic [iol_pkg::FOUND_W-1:0]  found_position;
  logic [iol_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output popped_word, output found_position,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input popped_word, input found_position,
                  input occupancy, output ready);
endinterface

>>> rtl/iol_cell.sv
// iol_cell: one list slot. Holds a word, shifts with its neighbors on insert/pop,
// and registers its leaf entry for the selection tree. Depends on iol_pkg.
`timescale 1ns / 1ps

module iol_cell (
  input  logic                       clk,
  input  logic [iol_pkg::IDX_W-1:0]  idx,
  input  iol_pkg::cell_ctrl_t        ctrl,
  input  logic [iol_pkg::WORD_W-1:0] left_word,
  input  logic [iol_pkg::WORD_W-1:0] right_word,
  output logic [iol_pkg::WORD_W-1:0] word,
  output iol_pkg::node_t             leaf
);

  logic [iol_pkg::WORD_W-1:0] word_next;
  logic                       after_at;
  logic                       at_here;
  logic                       in_list;
  iol_pkg::node_t             leaf_next;

  assign after_at = idx > ctrl.at;
  assign at_here  = idx == ctrl.at;
  assign in_list  = iol_pkg::CNT_W'(idx) < ctrl.count;

  // Insert pulls from the left, pop pulls from the right
  always_comb begin
    word_next = word;
    if (ctrl.ins_en) begin
      if (after_at) begin
        word_next = left_word;
      end else if (at_here) begin
        word_next = ctrl.key;
      end
    end else if (ctrl.pop_en) begin
      if (after_at || at_here) begin
        word_next = right_word;
      end
    end
  end

  // Leaf entry sees the word before any shift
  always_comb begin
    leaf_next.hit  = (ctrl.sel_find && in_list && (word == ctrl.key)) ||
                     (ctrl.sel_pop && at_here);
    leaf_next.idx  = idx;
    leaf_next.word = word;
  end

  always_ff @(posedge clk) begin
    word <= word_next;
    leaf <= leaf_next;
  end

endmodule

>>> rtl/iol_merge.sv
// iol_merge: one registered node of the selection tree; passes on the lowest
// child with its hit flag set. Depends on iol_pkg.
`timescale 1ns / 1ps

module iol_merge (
  input  logic                                 clk,
  input  iol_pkg::node_t [iol_pkg::RADIX-1:0]  kids,
  output iol_pkg::node_t                       node
);

  iol_pkg::node_t pick;

  // Lowest-numbered hit wins
  always_comb begin
    pick = kids[iol_pkg::RADIX-1];
    for (int k = iol_pkg::RADIX - 2; k >= 0; k--) begin
      if (kids[k].hit) begin
        pick = kids[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    node <= pick;
  end

endmodule

>>> rtl/indexed_ordered_list.sv
// indexed_ordered_list: ordered list of CAPACITY words held in a chain of cells.
// A request is registered, applied to the cells, walked up the selection tree and
// loaded into the output register. LVL is the depth of the radix-8 selection tree over
// the cells (3 for 256 entries). A new request waits until the last result is loaded.
// Reset (synchronous, rst high) empties the list and drops any pending response;
// cell contents are left as they are.
`timescale 1ns / 1ps

module indexed_ordered_list (
  input  logic          clk,
  input  logic          rst,
  iol_req_if.sink       req,
  iol_rsp_if.source     rsp
);

  localparam int CNT_W = iol_pkg::CNT_W;
  localparam int IDX_W = iol_pkg::IDX_W;
  localparam int CMP_W = iol_pkg::CMP_W;
  localparam int POS_W = iol_pkg::POS_W;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT, S_DONE} state_t;

  state_t                          state;
  logic [CNT_W-1:0]                count;
  logic [iol_pkg::WAIT_W-1:0]      wait_cnt;

  // Registered command
  logic                            cmd_ins;
  logic                            cmd_pop;
  logic                            cmd_find;
  logic [IDX_W-1:0]                cmd_at;
  logic [iol_pkg::WORD_W-1:0]      cmd_key;
  logic [iol_pkg::STATUS_W-1:0]    cmd_status;

  // Held result and output register
  logic [iol_pkg::STATUS_W-1:0]    res_status;
  logic [iol_pkg::WORD_W-1:0]      res_popped;
  logic [iol_pkg::FOUND_W-1:0]     res_found;
  logic [iol_pkg::OCC_W-1:0]       res_occ;
  logic                            out_valid;
  logic [iol_pkg::STATUS_W-1:0]    out_status;
  logic [iol_pkg::WORD_W-1:0]      out_popped;
  logic [iol_pkg::FOUND_W-1:0]     out_found;
  logic [iol_pkg::OCC_W-1:0]       out_occ;

  // Request decode
  logic                            dec_ins;
  logic                            dec_pop;
  logic                            dec_find;
  logic [IDX_W-1:0]                dec_at;
  logic [iol_pkg::STATUS_W-1:0]    dec_status;
  logic [CMP_W-1:0]                pos_ext;
  logic [CMP_W-1:0]                cnt_ext;
  logic [CNT_W-1:0]                cnt_dec;
  logic                            pos_neg;
  logic                            pos_last;
  logic                            pos_ge_cnt;

  iol_pkg::cell_ctrl_t             ctrl;
  logic [iol_pkg::WORD_W-1:0]      cell_word [iol_pkg::CAPACITY];
  iol_pkg::node_t                  tree_node [iol_pkg::TOTAL];
  iol_pkg::node_t                  root;

  logic                            req_fire;
  logic                            rsp_fire;

  assign req_fire = req.valid && req.ready;
  assign rsp_fire = out_valid && rsp.ready;

  // Position arithmetic
  assign pos_ext    = {{(CMP_W - POS_W){req.position[POS_W-1]}}, req.position};
  assign cnt_ext    = CMP_W'(count);
  assign cnt_dec    = count - CNT_W'(1);
  assign pos_neg    = req.position[POS_W-1];
  assign pos_last   = req.position == '1;
  assign pos_ge_cnt = !pos_neg && (pos_ext >= cnt_ext);

  always_comb begin
    dec_ins    = 1'b0;
    dec_pop    = 1'b0;
    dec_find   = 1'b0;
    dec_at     = '0;
    dec_status = iol_pkg::STAT_OK;
    unique case (req.action)
      iol_pkg::ACT_INSERT: begin
        if (count == CNT_W'(iol_pkg::CAPACITY)) begin
          dec_status = iol_pkg::STAT_FULL;
        end else begin
          dec_ins = 1'b1;
          if (pos_last || pos_ge_cnt) begin
            dec_at = count[IDX_W-1:0];
          end else if (pos_neg) begin
            dec_at = '0;
          end else begin
            dec_at = pos_ext[IDX_W-1:0];
          end
        end
      end
      iol_pkg::ACT_POP: begin
        if (count == '0) begin
          dec_status = iol_pkg::STAT_RANGE;
        end else if (pos_last) begin
          dec_pop = 1'b1;
          dec_at  = cnt_dec[IDX_W-1:0];
        end else if (pos_neg || pos_ge_cnt) begin
          dec_status = iol_pkg::STAT_RANGE;
        end else begin
          dec_pop = 1'b1;
          dec_at  = pos_ext[IDX_W-1:0];
        end
      end
      iol_pkg::ACT_FIND: begin
        dec_find = 1'b1;
      end
      default: begin
        dec_status = iol_pkg::STAT_OK;
      end
    endcase
  end

  // Broadcast to the cells; shifts happen only in the execute cycle
  always_comb begin
    ctrl.ins_en   = (state == S_EXEC) && cmd_ins;
    ctrl.pop_en   = (state == S_EXEC) && cmd_pop;
    ctrl.sel_find = cmd_find;
    ctrl.sel_pop  = cmd_pop;
    ctrl.at       = cmd_at;
    ctrl.count    = count;
    ctrl.key      = cmd_key;
  end

  // Cell chain
  for (genvar i = 0; i < iol_pkg::CAPACITY; i++) begin : g_cell
    logic [iol_pkg::WORD_W-1:0] lw;
    logic [iol_pkg::WORD_W-1:0] rw;
    if (i == 0) begin : g_first
      assign lw = '0;
    end else begin : g_mid_l
      assign lw = cell_word[i-1];
    end
    if (i == iol_pkg::CAPACITY - 1) begin : g_last
      assign rw = '0;
    end else begin : g_mid_r
      assign rw = cell_word[i+1];
    end
    iol_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_word  (lw),
      .right_word (rw),
      .word       (cell_word[i]),
      .leaf       (tree_node[i])
    );
  end

  // Padding leaves never hit
  for (genvar i = iol_pkg::CAPACITY; i < iol_pkg::PAD; i++) begin : g_pad
    assign tree_node[i] = '0;
  end

  // Registered selection tree
  for (genvar lv = 1; lv <= iol_pkg::LVL; lv++) begin : g_lvl
    for (genvar n = 0; n < iol_pkg::RADIX ** (iol_pkg::LVL - lv); n++) begin : g_node
      localparam int BASE = iol_pkg::level_off(lv - 1) + n * iol_pkg::RADIX;
      localparam int DEST = iol_pkg::level_off(lv) + n;
      iol_pkg::node_t [iol_pkg::RADIX-1:0] kids;
      for (genvar c = 0; c < iol_pkg::RADIX; c++) begin : g_kid
        assign kids[c] = tree_node[BASE + c];
      end
      iol_merge u_merge (
        .clk  (clk),
        .kids (kids),
        .node (tree_node[DEST])
      );
    end
  end

  assign root = tree_node[iol_pkg::TOTAL - 1];

  // Sequencer, count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      wait_cnt  <= '0;
    end else begin
      // A new result loaded in S_DONE keeps the register full
      if (rsp_fire && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            cmd_ins    <= dec_ins;
            cmd_pop    <= dec_pop;
            cmd_find   <= dec_find;
            cmd_at     <= dec_at;
            cmd_key    <= req.data_word;
            cmd_status <= dec_status;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_ins) begin
            count <= count + CNT_W'(1);
          end else if (cmd_pop) begin
            count <= cnt_dec;
          end
          wait_cnt <= iol_pkg::WAIT_W'(iol_pkg::LVL);
          state    <= S_WAIT;
        end
        S_WAIT: begin
          if (wait_cnt == '0) begin
            // Root now holds the snapshot taken in the execute cycle
            if (cmd_find) begin
              res_status <= root.hit ? iol_pkg::STAT_OK : iol_pkg::STAT_NOTFOUND;
              res_found  <= root.hit ? iol_pkg::FOUND_W'(root.idx) : '0;
            end else begin
              res_status <= cmd_status;
              res_found  <= '0;
            end
            res_popped <= cmd_pop ? root.word : '0;
            res_occ    <= iol_pkg::OCC_W'(count);
            state      <= S_DONE;
          end else begin
            wait_cnt <= wait_cnt - iol_pkg::WAIT_W'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_popped <= res_popped;
            out_found  <= res_found;
            out_occ    <= res_occ;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready          = state == S_IDLE;
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.popped_word    = out_popped;
  assign rsp.found_position = out_found;
  assign rsp.occupancy      = out_occ;

endmodule
